FILE: rtl/core/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants of the fixed-point PageRank engine.
// ----------------------------------------------------------------------------
package pgr_pkg;

    localparam int DEF_VERTEX_DEPTH = 4096;
    localparam int DEF_EDGE_DEPTH   = 32768;

    localparam logic [12:0] RST_VERTEX_COUNT = 13'd4096;
    localparam logic [23:0] RST_RANK_SCALE   = 24'd1000000;
    localparam logic [7:0]  RST_DAMPING_NUM  = 8'd85;
    localparam logic [7:0]  RST_DAMPING_DEN  = 8'd100;

    localparam logic [7:0] CFG_VERTEX_COUNT = 8'd0;
    localparam logic [7:0] CFG_RANK_SCALE   = 8'd1;
    localparam logic [7:0] CFG_DAMPING_NUM  = 8'd2;
    localparam logic [7:0] CFG_DAMPING_DEN  = 8'd3;

    typedef enum logic [2:0] {
        OP_ROW_WR  = 3'd0,
        OP_DEG_WR  = 3'd1,
        OP_EDGE_WR = 3'd2,
        OP_INIT    = 3'd3,
        OP_ITER    = 3'd4,
        OP_READ    = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_INIT,
        S_IWAIT,
        S_INIT_WR,
        S_BASE,
        S_BWAIT,
        S_ROW0,
        S_ROW1,
        S_ROW2,
        S_EDGE,
        S_TGT,
        S_DEG,
        S_EWAIT,
        S_MUL,
        S_SDIV,
        S_SWAIT,
        S_CP_RD,
        S_CP_WR,
        S_RESP
    } t_state;

    // effective configuration handed to the core
    typedef struct packed {
        logic [23:0] scale;
        logic [7:0]  num;
        logic [7:0]  den;
    } t_cfg;

    typedef struct packed {
        logic [31:0] rank;
        logic        status;
    } t_res;

endpackage

FILE: rtl/core/pgr_div.sv
// ----------------------------------------------------------------------------
// pgr_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pgr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {r_rem, r_q[63]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/pgr_core.sv
// ----------------------------------------------------------------------------
// pgr_core
// Graph and rank memories with the sequencer that runs every request.
// ----------------------------------------------------------------------------
module pgr_core
    import pgr_pkg::*;
#(
    parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
    parameter int EDGE_DEPTH   = DEF_EDGE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_opcode,
    input  logic [14:0]                       i_index,
    input  logic [15:0]                       i_value,
    input  t_cfg                              i_cfg,
    input  logic [$clog2(VERTEX_DEPTH+1)-1:0] i_count,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output t_res                              o_res
);

    localparam int VW = $clog2(VERTEX_DEPTH);
    localparam int RW = $clog2(VERTEX_DEPTH + 1);
    localparam int EW = $clog2(EDGE_DEPTH);
    localparam int PW = $clog2(EDGE_DEPTH + 1);

    logic [PW-1:0] m_row  [VERTEX_DEPTH+1];
    logic [15:0]   m_deg  [VERTEX_DEPTH];
    logic [VW-1:0] m_edge [EDGE_DEPTH];
    logic [31:0]   m_old  [VERTEX_DEPTH];
    logic [31:0]   m_new  [VERTEX_DEPTH];

    logic [PW-1:0] d_row;
    logic [15:0]   d_deg;
    logic [VW-1:0] d_edge;
    logic [31:0]   d_old;
    logic [31:0]   d_new;

    t_state r_state, n_state;
    logic [2:0]    r_op;
    logic [14:0]   r_idx;
    logic [15:0]   r_val;
    logic [RW-1:0] r_v, n_v;
    logic [PW-1:0] r_e, n_e;
    logic [PW-1:0] r_end, n_end;
    logic [63:0]   r_sum, n_sum;
    logic [63:0]   r_prod, n_prod;
    logic [31:0]   r_base, n_base;
    logic [31:0]   r_init, n_init;
    logic [31:0]   r_rank, n_rank;
    logic          r_status, n_status;

    logic [RW-1:0] a_row;
    logic [EW-1:0] a_edge;
    logic [VW-1:0] a_vtx;
    logic [VW-1:0] a_new;
    logic          w_row, w_deg, w_edge, w_old, w_new;
    logic [31:0]   w_old_data, w_new_data;

    logic          div_start, div_done;
    logic [63:0]   div_dvd, div_quot;
    logic [31:0]   div_dvs;

    logic [31:0]   ix32, vl32;
    logic [63:0]   rank_sum;
    logic [RW-1:0] v_next;

    assign ix32     = 32'(r_idx);
    assign vl32     = 32'(r_val);
    assign v_next   = r_v + RW'(1);
    assign rank_sum = 64'(r_base) + div_quot;

    pgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_row) m_row[ix32[RW-1:0]] <= vl32[PW-1:0];
        d_row <= m_row[a_row];
    end

    always_ff @(posedge i_clk) begin
        if (w_deg) m_deg[ix32[VW-1:0]] <= r_val;
        d_deg <= m_deg[a_vtx];
    end

    always_ff @(posedge i_clk) begin
        if (w_edge) m_edge[ix32[EW-1:0]] <= vl32[VW-1:0];
        d_edge <= m_edge[a_edge];
    end

    always_ff @(posedge i_clk) begin
        if (w_old) m_old[r_v[VW-1:0]] <= w_old_data;
        d_old <= m_old[a_vtx];
    end

    always_ff @(posedge i_clk) begin
        if (w_new) m_new[r_v[VW-1:0]] <= w_new_data;
        d_new <= m_new[a_new];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= i_opcode;
            r_idx <= i_index;
            r_val <= i_value;
        end
        r_v      <= n_v;
        r_e      <= n_e;
        r_end    <= n_end;
        r_sum    <= n_sum;
        r_prod   <= n_prod;
        r_base   <= n_base;
        r_init   <= n_init;
        r_rank   <= n_rank;
        r_status <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_v        = r_v;
        n_e        = r_e;
        n_end      = r_end;
        n_sum      = r_sum;
        n_prod     = r_prod;
        n_base     = r_base;
        n_init     = r_init;
        n_rank     = r_rank;
        n_status   = r_status;
        a_row      = r_v;
        a_edge     = r_e[EW-1:0];
        a_vtx      = d_edge;
        a_new      = r_v[VW-1:0];
        w_row      = 1'b0;
        w_deg      = 1'b0;
        w_edge     = 1'b0;
        w_old      = 1'b0;
        w_new      = 1'b0;
        w_old_data = r_init;
        w_new_data = '0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        o_ready    = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_rank   = '0;
                n_status = 1'b0;
                n_v      = '0;
                n_state  = S_RESP;
                priority case (r_op)
                    OP_ROW_WR: begin
                        if (ix32 > 32'(VERTEX_DEPTH) || vl32 > 32'(EDGE_DEPTH)) n_status = 1'b1;
                        else w_row = 1'b1;
                    end
                    OP_DEG_WR: begin
                        if (ix32 >= 32'(VERTEX_DEPTH)) n_status = 1'b1;
                        else w_deg = 1'b1;
                    end
                    OP_EDGE_WR: begin
                        if (ix32 >= 32'(EDGE_DEPTH) || vl32 >= 32'(VERTEX_DEPTH)) begin
                            n_status = 1'b1;
                        end else begin
                            w_edge = 1'b1;
                        end
                    end
                    OP_INIT: n_state = S_INIT;
                    OP_ITER: begin
                        n_base  = '0;
                        n_state = (i_cfg.num < i_cfg.den) ? S_BASE : S_ROW0;
                    end
                    OP_READ: begin
                        a_vtx = ix32[VW-1:0];
                        if (ix32 >= 32'(i_count)) n_status = 1'b1;
                        else n_state = S_RD_WAIT;
                    end
                    default: n_status = 1'b1;
                endcase
            end
            S_RD_WAIT: begin
                n_rank  = d_old;
                n_state = S_RESP;
            end
            S_INIT: begin
                div_start = 1'b1;
                div_dvd   = 64'(i_cfg.scale);
                div_dvs   = 32'(i_count);
                n_state   = S_IWAIT;
            end
            S_IWAIT: begin
                if (div_done) begin
                    n_init  = div_quot[31:0];
                    n_state = S_INIT_WR;
                end
            end
            S_INIT_WR: begin
                w_old = 1'b1;
                n_v   = v_next;
                if (v_next == i_count) n_state = S_RESP;
            end
            S_BASE: begin
                div_start = 1'b1;
                div_dvd   = 64'(32'(i_cfg.scale) * 32'(i_cfg.den - i_cfg.num));
                div_dvs   = 32'(i_cfg.den) * 32'(i_count);
                n_state   = S_BWAIT;
            end
            S_BWAIT: begin
                if (div_done) begin
                    n_base  = div_quot[31:0];
                    n_state = S_ROW0;
                end
            end
            S_ROW0: begin
                n_sum   = '0;
                n_state = S_ROW1;
            end
            S_ROW1: begin
                a_row   = v_next;
                n_e     = d_row;
                n_state = S_ROW2;
            end
            S_ROW2: begin
                n_end   = d_row;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (r_e >= r_end) n_state = S_MUL;
                else n_state = S_TGT;
            end
            S_TGT: n_state = S_DEG;
            S_DEG: begin
                if (d_deg == 16'd0) begin
                    n_e     = r_e + PW'(1);
                    n_state = S_EDGE;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = 64'(d_old);
                    div_dvs   = 32'(d_deg);
                    n_state   = S_EWAIT;
                end
            end
            S_EWAIT: begin
                if (div_done) begin
                    n_sum   = r_sum + div_quot;
                    n_e     = r_e + PW'(1);
                    n_state = S_EDGE;
                end
            end
            S_MUL: begin
                n_prod  = 64'(r_sum * i_cfg.num);
                n_state = S_SDIV;
            end
            S_SDIV: begin
                div_start = 1'b1;
                div_dvd   = r_prod;
                div_dvs   = 32'(i_cfg.den);
                n_state   = S_SWAIT;
            end
            S_SWAIT: begin
                if (div_done) begin
                    w_new = 1'b1;
                    // saturate at the top of the rank range
                    w_new_data = (rank_sum[63:32] != 32'd0) ? 32'hFFFF_FFFF : rank_sum[31:0];
                    if (v_next == i_count) begin
                        n_v     = '0;
                        n_state = S_CP_RD;
                    end else begin
                        n_v     = v_next;
                        n_state = S_ROW0;
                    end
                end
            end
            S_CP_RD: n_state = S_CP_WR;
            S_CP_WR: begin
                w_old      = 1'b1;
                w_old_data = d_new;
                n_v        = v_next;
                n_state    = (v_next == i_count) ? S_RESP : S_CP_RD;
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res.rank   = r_rank;
    assign o_res.status = r_status;

endmodule

FILE: rtl/core/fixed_point_pagerank_engine.sv
// ----------------------------------------------------------------------------
// fixed_point_pagerank_engine
// Pull-style fixed-point PageRank over a CSR graph held in on-chip memories.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready (opcode, index, value); each gives one
// result on o_valid/i_ready (rank, status). Config registers are written on
// the i_cfg_valid/o_cfg_ready channel; the user must write them only while no
// request is in flight; the block does not enforce it. Row, degree and edge
// writes and bad requests go from S_EXEC to S_RESP, a rank read via S_RD_WAIT.
// Init runs one divide, then one rank write per vertex. Iterate walks the
// edges of each vertex; every edge whose source has nonzero degree goes
// through the single shared bit-serial divider.
// One request is processed at a time; a finished result sits in the output
// register, so the next request is taken while the receiver stalls.
// Reset returns the config registers to their defaults and the sequencer to
// idle; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module fixed_point_pagerank_engine
    import pgr_pkg::*;
#(
    parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
    parameter int EDGE_DEPTH   = DEF_EDGE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [14:0] i_index,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_rank,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int RW = $clog2(VERTEX_DEPTH + 1);

    logic [12:0] r_vcount;
    logic [23:0] r_scale;
    logic [7:0]  r_num;
    logic [7:0]  r_den;
    logic        r_ovalid;
    t_res        r_out;

    t_cfg          cfg;
    logic [RW-1:0] count;
    logic          res_valid, res_ready;
    t_res          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= RST_VERTEX_COUNT;
            r_scale  <= RST_RANK_SCALE;
            r_num    <= RST_DAMPING_NUM;
            r_den    <= RST_DAMPING_DEN;
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data[12:0];
                CFG_RANK_SCALE:   r_scale  <= i_cfg_data[23:0];
                CFG_DAMPING_NUM:  r_num    <= i_cfg_data[7:0];
                CFG_DAMPING_DEN:  r_den    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // zero count acts as one, oversize count clamps to the store depth
    always_comb begin
        if (r_vcount == 13'd0) count = RW'(1);
        else if (32'(r_vcount) > 32'(VERTEX_DEPTH)) count = RW'(VERTEX_DEPTH);
        else count = RW'(r_vcount);
        cfg.scale = r_scale;
        cfg.num   = r_num;
        cfg.den   = (r_den == 8'd0) ? 8'd1 : r_den;
    end

    pgr_core #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .EDGE_DEPTH   (EDGE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_cfg       (cfg),
        .i_count     (count),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_out <= res;
    end

    assign o_valid  = r_ovalid;
    assign o_rank   = r_out.rank;
    assign o_status = r_out.status;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of fixed_point_pagerank_engine: small CSR graphs are loaded,
// ranks are initialized, iterated and read back. Each result is checked
// against an in-bench model of the engine, with random gaps on the request
// side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    import pgr_pkg::*;

    localparam int VDEPTH = DEF_VERTEX_DEPTH;
    localparam int EDEPTH = DEF_EDGE_DEPTH;
    localparam int WDOG_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_opcode = '0;
    logic [14:0] i_index = '0;
    logic [15:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_rank;
    logic        o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    fixed_point_pagerank_engine dut (.*);

    always #6 i_clk = ~i_clk;

    // model state
    logic [12:0] m_vcount = RST_VERTEX_COUNT;
    logic [23:0] m_scale  = RST_RANK_SCALE;
    logic [7:0]  m_num    = RST_DAMPING_NUM;
    logic [7:0]  m_den    = RST_DAMPING_DEN;
    logic [15:0] m_row [0:VDEPTH];
    logic [15:0] m_deg [0:VDEPTH-1];
    logic [11:0] m_tgt [0:EDEPTH-1];
    logic [31:0] m_old [0:VDEPTH-1];
    logic [31:0] m_new [0:VDEPTH-1];

    t_res rank_q[$];
    int   errors = 0;
    int   burst_left = 0;
    int   hold_cycles = 0;
    int   idle_cnt = 0;

    function automatic int eff_n();
        if (m_vcount == 0) return 1;
        if (m_vcount > VDEPTH) return VDEPTH;
        return m_vcount;
    endfunction

    task automatic iterate_model();
        int n;
        longint unsigned num, den, base, sum, r;
        int e, e_end;
        n = eff_n();
        num = m_num;
        den = (m_den == 0) ? 1 : m_den;
        base = 0;
        if (num < den) base = (longint'(m_scale) * (den - num)) / (den * n);
        for (int v = 0; v < n; v++) begin
            sum = 0;
            e = m_row[v];
            e_end = m_row[v+1];
            if (e_end > EDEPTH) e_end = EDEPTH;
            for (; e < e_end; e++) begin
                if (m_deg[m_tgt[e]] != 0)
                    sum += longint'(m_old[m_tgt[e]]) / m_deg[m_tgt[e]];
            end
            r = base + (num * sum) / den;
            if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
            m_new[v] = r[31:0];
        end
        for (int v = 0; v < n; v++) begin
            m_old[v] = m_new[v];
            m_new[v] = 0;
        end
    endtask

    task automatic predict_rank(input logic [2:0] op, input logic [14:0] idx,
                                input logic [15:0] val);
        t_res res;
        int n;
        n = eff_n();
        res = '0;
        case (op)
            OP_ROW_WR: begin
                if (idx > VDEPTH || val > EDEPTH) res.status = 1'b1;
                else m_row[idx] = val;
            end
            OP_DEG_WR: begin
                if (idx >= VDEPTH) res.status = 1'b1;
                else m_deg[idx] = val;
            end
            OP_EDGE_WR: begin
                if (idx >= EDEPTH || val >= VDEPTH) res.status = 1'b1;
                else m_tgt[idx] = val[11:0];
            end
            OP_INIT: begin
                for (int v = 0; v < n; v++) begin
                    m_old[v] = m_scale / n;
                    m_new[v] = 0;
                end
            end
            OP_ITER: iterate_model();
            OP_READ: begin
                if (idx >= n) res.status = 1'b1;
                else res.rank = m_old[idx];
            end
            default: res.status = 1'b1;
        endcase
        rank_q.push_back(res);
    endtask

    // one request; sender runs in bursts with gaps in between
    task automatic send_req(input logic [2:0] op, input logic [14:0] idx,
                            input logic [15:0] val);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_index  <= idx;
        i_value  <= val;
        do @(posedge i_clk); while (!o_ready);
        predict_rank(op, idx, val);
        burst_left--;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (rank_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] reg_idx, input logic [31:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (reg_idx)
            CFG_VERTEX_COUNT: m_vcount = data[12:0];
            CFG_RANK_SCALE:   m_scale  = data[23:0];
            CFG_DAMPING_NUM:  m_num    = data[7:0];
            CFG_DAMPING_DEN:  m_den    = data[7:0];
            default: ;
        endcase
    endtask

    // result side: random stall pattern plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (rank_q.size() == 0) begin
                $error("unexpected result rank=%0d status=%0d", o_rank, o_status);
                errors++;
            end else begin
                exp_res = rank_q.pop_front();
                if (o_rank !== exp_res.rank) begin
                    $error("rank: expected %0d, got %0d", exp_res.rank, o_rank);
                    errors++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // field extremes and range checks of the write and read paths
    task automatic test_bounds();
        send_req(OP_ROW_WR, 15'd4096, 16'd0);
        send_req(OP_ROW_WR, 15'd4097, 16'd0);
        send_req(OP_ROW_WR, 15'd0, 16'd32769);
        send_req(OP_ROW_WR, 15'h7FFF, 16'hFFFF);
        send_req(OP_DEG_WR, 15'd4095, 16'hFFFF);
        send_req(OP_DEG_WR, 15'd4096, 16'd1);
        send_req(OP_EDGE_WR, 15'h7FFF, 16'd4095);
        send_req(OP_EDGE_WR, 15'd5, 16'd4096);
        send_req(3'd6, 15'h7FFF, 16'hFFFF);
        send_req(3'd7, 15'd0, 16'd0);
        send_req(OP_INIT, 15'd0, 16'd0);
        send_req(OP_READ, 15'd0, 16'd0);
        send_req(OP_READ, 15'd4095, 16'd0);
        send_req(OP_READ, 15'd4096, 16'd0);
        send_req(OP_READ, 15'h7FFF, 16'd0);
    endtask

    // vertex count extremes: zero acts as one, above depth acts as depth
    task automatic test_vcount_limits();
        write_cfg(CFG_VERTEX_COUNT, 32'd8191);
        send_req(OP_READ, 15'd4095, 16'd0);
        send_req(OP_READ, 15'd4096, 16'd0);
        write_cfg(CFG_VERTEX_COUNT, 32'hFFFF_E000);
        send_req(OP_INIT, 15'd0, 16'd0);
        send_req(OP_READ, 15'd0, 16'd0);
        send_req(OP_READ, 15'd1, 16'd0);
    endtask

    // empty and reversed ranges, zero-degree neighbor, range ending at store end
    task automatic test_small_graph();
        write_cfg(CFG_VERTEX_COUNT, 32'd4);
        write_cfg(CFG_RANK_SCALE, 32'd1000000);
        write_cfg(CFG_DAMPING_NUM, 32'd85);
        write_cfg(CFG_DAMPING_DEN, 32'd100);
        send_req(OP_ROW_WR, 15'd0, 16'd32766);
        send_req(OP_ROW_WR, 15'd1, 16'd32768);
        send_req(OP_ROW_WR, 15'd2, 16'd0);
        send_req(OP_ROW_WR, 15'd3, 16'd3);
        send_req(OP_ROW_WR, 15'd4, 16'd3);
        send_req(OP_DEG_WR, 15'd0, 16'd2);
        send_req(OP_DEG_WR, 15'd1, 16'd0);
        send_req(OP_DEG_WR, 15'd2, 16'd1);
        send_req(OP_DEG_WR, 15'd3, 16'hFFFF);
        send_req(OP_EDGE_WR, 15'd32766, 16'd1);
        send_req(OP_EDGE_WR, 15'd32767, 16'd2);
        send_req(OP_EDGE_WR, 15'd0, 16'd0);
        send_req(OP_EDGE_WR, 15'd1, 16'd3);
        send_req(OP_EDGE_WR, 15'd2, 16'd2);
        send_req(OP_INIT, 15'd0, 16'd0);
        send_req(OP_ITER, 15'd0, 16'd0);
        for (int v = 0; v < 4; v++) send_req(OP_READ, v[14:0], 16'd0);
        write_cfg(CFG_DAMPING_DEN, 32'd0);
        send_req(OP_ITER, 15'd0, 16'd0);
        for (int v = 0; v < 4; v++) send_req(OP_READ, v[14:0], 16'd0);
    endtask

    // self loop with maximum scale and gain drives the rank into saturation
    task automatic test_saturation();
        write_cfg(CFG_VERTEX_COUNT, 32'd1);
        write_cfg(CFG_RANK_SCALE, 32'hFFFF_FFFF);
        write_cfg(CFG_DAMPING_NUM, 32'd255);
        write_cfg(CFG_DAMPING_DEN, 32'd1);
        send_req(OP_ROW_WR, 15'd0, 16'd10);
        send_req(OP_ROW_WR, 15'd1, 16'd11);
        send_req(OP_EDGE_WR, 15'd10, 16'd0);
        send_req(OP_DEG_WR, 15'd0, 16'd1);
        send_req(OP_INIT, 15'd0, 16'd0);
        send_req(OP_ITER, 15'd0, 16'd0);
        send_req(OP_READ, 15'd0, 16'd0);
        send_req(OP_ITER, 15'd0, 16'd0);
        send_req(OP_READ, 15'd0, 16'd0);
        write_cfg(CFG_RANK_SCALE, 32'd1);
        write_cfg(CFG_DAMPING_NUM, 32'd0);
        write_cfg(CFG_DAMPING_DEN, 32'd255);
        send_req(OP_INIT, 15'd0, 16'd0);
        send_req(OP_ITER, 15'd0, 16'd0);
        send_req(OP_READ, 15'd0, 16'd0);
    endtask

    // result side held off while requests keep coming
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 12; k++) send_req(OP_READ, 15'($urandom_range(0, 1)), 16'd0);
    endtask

    // harmless filler: reads, bad opcodes, rejected writes and degree writes beyond the graph
    task automatic send_noise(input int n);
        case ($urandom_range(0, 6))
            0: send_req(OP_READ, 15'($urandom_range(0, n + 2)), 16'($urandom));
            1: send_req(3'($urandom_range(6, 7)), 15'($urandom), 16'($urandom));
            2: send_req(OP_ROW_WR, 15'($urandom_range(4097, 32767)), 16'($urandom));
            3: send_req(OP_ROW_WR, 15'($urandom_range(0, 4096)),
                        16'($urandom_range(32769, 65535)));
            4: send_req(OP_DEG_WR, 15'($urandom_range(4096, 32767)), 16'($urandom));
            5: send_req(OP_EDGE_WR, 15'($urandom), 16'($urandom_range(4096, 65535)));
            default: send_req(OP_DEG_WR, 15'($urandom_range(16, 4095)), 16'($urandom));
        endcase
    endtask

    task automatic test_random_graphs();
        int n, slot, cnt;
        for (int round = 0; round < 1; round++) begin
            n = $urandom_range(1, 8);
            write_cfg(CFG_VERTEX_COUNT, n);
            write_cfg(CFG_RANK_SCALE, $urandom);
            write_cfg(CFG_DAMPING_NUM, $urandom);
            write_cfg(CFG_DAMPING_DEN, $urandom_range(0, 255));
            slot = $urandom_range(0, EDEPTH - 40);
            for (int v = 0; v < n; v++) begin
                cnt = $urandom_range(0, 4);
                send_req(OP_ROW_WR, v[14:0], 16'(slot));
                for (int k = 0; k < cnt; k++) begin
                    send_req(OP_EDGE_WR, 15'(slot), 16'($urandom_range(0, n - 1)));
                    slot++;
                    if ($urandom_range(0, 3) == 0) send_noise(n);
                end
            end
            send_req(OP_ROW_WR, n[14:0], 16'(slot));
            for (int v = 0; v < n; v++)
                send_req(OP_DEG_WR, v[14:0],
                         ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
            send_req(OP_INIT, 15'd0, 16'd0);
            for (int it = 0; it < 3; it++) begin
                send_req(OP_ITER, 15'd0, 16'd0);
                for (int k = 0; k < 3; k++) send_noise(n);
                send_req(OP_READ, 15'($urandom_range(0, n - 1)), 16'd0);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bounds();
        test_vcount_limits();
        test_small_graph();
        test_saturation();
        test_backpressure();
        test_random_graphs();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && rank_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
